@@ rtl/height_slope_colorizer_assert.svh @@
// Assertion macros for the height slope colorizer.
// Used by height_slope_colorizer.sv; expects i_clk and i_rst_n in the including scope.
`ifndef HEIGHT_SLOPE_COLORIZER_ASSERT_SVH
`define HEIGHT_SLOPE_COLORIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hsc_pkg.sv @@
// Shared types and constants of the height slope colorizer.
// No dependencies; used by the top level.
package hsc_pkg;

    typedef logic [7:0]      t_chan;
    typedef logic [2:0][7:0] t_rgb;   // index 0 red, 1 green, 2 blue

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HILL_DIVISOR = 2'd0;
    localparam t_cfg_idx CFG_SLOPE_LIMIT  = 2'd1;
    localparam t_cfg_idx CFG_CAP_HEIGHT   = 2'd2;
    localparam t_cfg_idx CFG_CAP_BAND     = 2'd3;

    localparam t_chan RST_HILL_DIVISOR = 8'd1;
    localparam t_chan RST_SLOPE_LIMIT  = 8'd5;
    localparam t_chan RST_CAP_HEIGHT   = 8'd175;
    localparam t_chan RST_CAP_BAND     = 8'd20;

    localparam t_chan CHAN_MAX = 8'd255;

    localparam t_rgb GRASS_RGB = {8'd56, 8'd128, 8'd96};
    localparam t_rgb TOP_RGB   = {8'd83, 8'd96, 8'd108};

    // Mountain minus grass, as magnitude and sign per channel.
    localparam int FADE1_W = 6;
    localparam logic [2:0][FADE1_W-1:0] FADE1_MAG = {6'd27, 6'd4, 6'd55};
    localparam logic [2:0]              FADE1_NEG = 3'b010;

    // Numerator widths of the two fades: 6x8 bits and 8x8 bits.
    localparam int NUM1_W = FADE1_W + 8;
    localparam int NUM2_W = 16;

endpackage

@@ rtl/height_slope_colorizer.sv @@
// Height slope colorizer top level: slope and height bands to one RGB color per pixel.
// Depends on hsc_pkg, hsc_div_pipe and height_slope_colorizer_assert.svh.
//
//   channel   handshake                     payload
//   input     i_valid / o_stall             i_height, i_horizontal_neighbor,
//                                           i_vertical_neighbor
//   output    o_valid / i_stall             o_red, o_green, o_blue
//   config    i_cfg_wr_en                   i_cfg_index, i_cfg_data
//
// One transaction per cycle while o_stall is low.
// The pipe is built from three divider pipelines of 8, 14 and 16 stages, one quotient
// bit per stage, plus three stages of slope and band logic.
// Reset is synchronous and active low; it loads the register defaults and empties the pipe.
// A stall on the output fills a one-entry skid register; only then is o_stall raised
// and the whole pipe holds.
module height_slope_colorizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_height,
    input  logic [7:0] i_horizontal_neighbor,
    input  logic [7:0] i_vertical_neighbor,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // Configuration registers.
    hsc_pkg::t_chan r_hill_div, r_slope_lim, r_cap_h, r_cap_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hill_div  <= hsc_pkg::RST_HILL_DIVISOR;
            r_slope_lim <= hsc_pkg::RST_SLOPE_LIMIT;
            r_cap_h     <= hsc_pkg::RST_CAP_HEIGHT;
            r_cap_band  <= hsc_pkg::RST_CAP_BAND;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hsc_pkg::CFG_HILL_DIVISOR: r_hill_div  <= i_cfg_data;
                hsc_pkg::CFG_SLOPE_LIMIT:  r_slope_lim <= i_cfg_data;
                hsc_pkg::CFG_CAP_HEIGHT:   r_cap_h     <= i_cfg_data;
                hsc_pkg::CFG_CAP_BAND:     r_cap_band  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero divisor acts as one; a zero slope limit only ever sees a zero slope.
    hsc_pkg::t_chan w_div, w_lim_den;
    assign w_div     = (r_hill_div == '0) ? 8'd1 : r_hill_div;
    assign w_lim_den = (r_slope_lim == '0) ? 8'd1 : r_slope_lim;

    logic r_skid_valid, r_out_valid;
    logic w_en;
    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // Stage group 1: absolute differences and height divided by the hill divisor.
    hsc_pkg::t_chan w_dx, w_dz;
    assign w_dx = (i_height >= i_horizontal_neighbor) ? i_height - i_horizontal_neighbor
                                                      : i_horizontal_neighbor - i_height;
    assign w_dz = (i_height >= i_vertical_neighbor) ? i_height - i_vertical_neighbor
                                                    : i_vertical_neighbor - i_height;

    logic                 w_v1;
    logic [2:0][7:0]      w_q1, w_r1;
    hsc_pkg::t_chan       w_side1;

    hsc_div_pipe #(.LANES(3), .NUM_W(8), .DEN_W(8), .SIDE_W(8)) u_div_hill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_num   ({i_height, w_dz, w_dx}),
        .i_den   (w_div),
        .i_side  (i_height),
        .o_valid (w_v1),
        .o_quot  (w_q1),
        .o_rem   (w_r1),
        .o_side  (w_side1)
    );

    // Slope, quantized height (height minus its remainder) and the grass fade numerators.
    hsc_pkg::t_chan w_smax, w_s, w_qh;
    logic [2:0][hsc_pkg::NUM1_W-1:0] w_p1;
    assign w_smax = (w_q1[0] > w_q1[1]) ? w_q1[0] : w_q1[1];
    assign w_s    = (w_smax > r_slope_lim) ? r_slope_lim : w_smax;
    assign w_qh   = w_side1 - w_r1[2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_p1[i] = hsc_pkg::NUM1_W'(w_s) * hsc_pkg::NUM1_W'(hsc_pkg::FADE1_MAG[i]);
        end
    end

    logic                            r_s2_valid;
    logic [2:0][hsc_pkg::NUM1_W-1:0] r_s2_num;
    hsc_pkg::t_chan                  r_s2_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= w_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_num <= w_p1;
            r_s2_q   <= w_qh;
        end
    end

    // Stage group 2: grass to mountain fade, divided by the slope limit.
    logic                            w_v2;
    logic [2:0][hsc_pkg::NUM1_W-1:0] w_q2;
    logic [2:0][7:0]                 w_r2;
    hsc_pkg::t_chan                  w_side2;

    hsc_div_pipe #(.LANES(3), .NUM_W(hsc_pkg::NUM1_W), .DEN_W(8), .SIDE_W(8)) u_div_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_valid),
        .i_num   (r_s2_num),
        .i_den   (w_lim_den),
        .i_side  (r_s2_q),
        .o_valid (w_v2),
        .o_quot  (w_q2),
        .o_rem   (w_r2),
        .o_side  (w_side2)
    );

    hsc_pkg::t_rgb w_c1;
    logic          w_in_band, w_in_snow;
    logic [8:0]    w_band_top;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c1[i] = hsc_pkg::FADE1_NEG[i] ? hsc_pkg::GRASS_RGB[i] - w_q2[i][7:0]
                                            : hsc_pkg::GRASS_RGB[i] + w_q2[i][7:0];
        end
    end

    // The band test q >= cap - band is done as q + band >= cap, so a band reaching
    // below zero starts at height zero.
    assign w_band_top = {1'b0, w_side2} + {1'b0, r_cap_band};
    assign w_in_band  = (r_cap_band != '0) && (w_band_top >= {1'b0, r_cap_h})
                        && (w_side2 < r_cap_h);
    assign w_in_snow  = (w_side2 >= r_cap_h) && (r_cap_h != hsc_pkg::CHAN_MAX);

    logic           r_s3_valid, r_s3_band;
    hsc_pkg::t_rgb  r_s3_c;
    hsc_pkg::t_chan r_s3_m, r_s3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= w_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_c    <= w_c1;
            r_s3_band <= w_in_band;
            if (w_in_band) begin
                r_s3_m   <= r_cap_h - w_side2;
                r_s3_den <= r_cap_band;
            end else if (w_in_snow) begin
                r_s3_m   <= hsc_pkg::CHAN_MAX - w_side2;
                r_s3_den <= hsc_pkg::CHAN_MAX - r_cap_h;
            end else begin
                // No fade: a zero numerator over one leaves the color as it is.
                r_s3_m   <= '0;
                r_s3_den <= 8'd1;
            end
        end
    end

    // Distance to the band or snow target, as magnitude and sign, times the fade amount.
    hsc_pkg::t_rgb                   w_tgt, w_mag;
    logic [2:0]                      w_neg;
    logic [2:0][hsc_pkg::NUM2_W-1:0] w_p2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_tgt[i] = r_s3_band ? hsc_pkg::TOP_RGB[i] : hsc_pkg::CHAN_MAX;
            w_neg[i] = (w_tgt[i] < r_s3_c[i]);
            w_mag[i] = w_neg[i] ? r_s3_c[i] - w_tgt[i] : w_tgt[i] - r_s3_c[i];
            w_p2[i]  = hsc_pkg::NUM2_W'(w_mag[i]) * hsc_pkg::NUM2_W'(r_s3_m);
        end
    end

    logic                            r_s4_valid;
    logic [2:0][hsc_pkg::NUM2_W-1:0] r_s4_prod;
    logic [2:0]                      r_s4_neg;
    hsc_pkg::t_rgb                   r_s4_c;
    hsc_pkg::t_chan                  r_s4_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_prod <= w_p2;
            r_s4_neg  <= w_neg;
            r_s4_c    <= r_s3_c;
            r_s4_den  <= r_s3_den;
        end
    end

    // Stage group 3: mountaintop or snow fade.
    logic                            w_v3;
    logic [2:0][hsc_pkg::NUM2_W-1:0] w_q3;
    logic [2:0][7:0]                 w_r3;
    logic [26:0]                     w_side3;

    hsc_div_pipe #(.LANES(3), .NUM_W(hsc_pkg::NUM2_W), .DEN_W(8), .SIDE_W(27)) u_div_cap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s4_valid),
        .i_num   (r_s4_prod),
        .i_den   (r_s4_den),
        .i_side  ({r_s4_neg, r_s4_c}),
        .o_valid (w_v3),
        .o_quot  (w_q3),
        .o_rem   (w_r3),
        .o_side  (w_side3)
    );

    hsc_pkg::t_rgb w_c3, w_fin;
    logic [2:0]    w_neg3;
    assign w_c3   = w_side3[23:0];
    assign w_neg3 = w_side3[26:24];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_fin[i] = w_neg3[i] ? w_c3[i] - w_q3[i][7:0] : w_c3[i] + w_q3[i][7:0];
        end
    end

    // Output register with a one-entry skid behind it.
    hsc_pkg::t_rgb r_out, r_skid;
    logic          w_take, w_out_from_skid, w_out_from_pipe, w_skid_load;
    logic          n_out_valid, n_skid_valid;

    assign w_take          = w_v3 && w_en;
    assign w_out_from_skid = r_skid_valid && !i_stall;
    assign w_out_from_pipe = w_take && (!r_out_valid || !i_stall);
    assign w_skid_load     = w_take && r_out_valid && i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_out_from_skid) begin
            n_skid_valid = 1'b0;
        end else if (w_out_from_pipe) begin
            n_out_valid = 1'b1;
        end else if (w_skid_load) begin
            n_skid_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_skid) begin
            r_out <= r_skid;
        end else if (w_out_from_pipe) begin
            r_out <= w_fin;
        end
        if (w_skid_load) begin
            r_skid <= w_fin;
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

`include "height_slope_colorizer_assert.svh"

    `HSC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `HSC_ASSERT_NEXT(a_skid_catches, w_skid_load, r_skid_valid, "result lost on stall")
    `HSC_ASSERT_NEXT(a_pipe_holds, !w_en, $stable(w_v3) && $stable(w_q3), "pipe moved while held")

endmodule

@@ rtl/hsc_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per stage, several lanes that share
// one divisor per transaction, with a sideband word carried alongside. No dependencies.
module hsc_div_pipe #(
    parameter int LANES  = 3,
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]               i_den,
    input  logic [SIDE_W-1:0]              i_side,
    output logic                           o_valid,
    output logic [LANES-1:0][NUM_W-1:0]    o_quot,
    output logic [LANES-1:0][DEN_W-1:0]    o_rem,
    output logic [SIDE_W-1:0]              o_side
);

    logic                        r_vld  [NUM_W];
    logic [LANES-1:0][DEN_W-1:0] r_rem  [NUM_W];
    logic [LANES-1:0][NUM_W-1:0] r_nq   [NUM_W];
    logic [DEN_W-1:0]            r_den  [NUM_W];
    logic [SIDE_W-1:0]           r_side [NUM_W];

    logic                        w_vld_p  [NUM_W];
    logic [LANES-1:0][DEN_W-1:0] w_rem_p  [NUM_W];
    logic [LANES-1:0][NUM_W-1:0] w_nq_p   [NUM_W];
    logic [DEN_W-1:0]            w_den_p  [NUM_W];
    logic [SIDE_W-1:0]           w_side_p [NUM_W];
    logic [LANES-1:0][DEN_W-1:0] n_rem    [NUM_W];
    logic [LANES-1:0][NUM_W-1:0] n_nq     [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign w_vld_p[k]  = i_valid;
            assign w_rem_p[k]  = '0;
            assign w_nq_p[k]   = i_num;
            assign w_den_p[k]  = i_den;
            assign w_side_p[k] = i_side;
        end else begin : g_next
            assign w_vld_p[k]  = r_vld[k-1];
            assign w_rem_p[k]  = r_rem[k-1];
            assign w_nq_p[k]   = r_nq[k-1];
            assign w_den_p[k]  = r_den[k-1];
            assign w_side_p[k] = r_side[k-1];
        end

        // The numerator shifts out at the top while quotient bits shift in at the bottom.
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W:0] w_trial;
            logic [DEN_W:0] w_diff;
            logic           w_ge;

            assign w_trial = {w_rem_p[k][l], w_nq_p[k][l][NUM_W-1]};
            assign w_diff  = w_trial - {1'b0, w_den_p[k]};
            assign w_ge    = (w_trial >= {1'b0, w_den_p[k]});
            assign n_rem[k][l] = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            assign n_nq[k][l]  = {w_nq_p[k][l][NUM_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_p[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem[k];
                r_nq[k]   <= n_nq[k];
                r_den[k]  <= w_den_p[k];
                r_side[k] <= w_side_p[k];
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quot  = r_nq[NUM_W-1];
    assign o_rem   = r_rem[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule
